### rtl/bpcw_pkg.sv
// ----------------------------------------------------------------------------
// bpcw_pkg
// Shared types, constants and bit-level helpers for the BLE CRC-24 and
// whitening encoder.
// ----------------------------------------------------------------------------
package bpcw_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned CrcW  = 24;
  localparam int unsigned ChanW = 6;

  localparam logic [CrcW-1:0]  CrcPoly      = 24'h00065B;
  localparam logic [CrcW-1:0]  CrcInitReset = 24'h555555;
  localparam logic [ByteW-1:0] WhitenTap    = 8'h11;
  localparam logic [ByteW-1:0] WhitenSeedOr = 8'h02;

  // Sequencer position within one input item: the data byte, then the
  // three CRC bytes when the item closes the packet.
  typedef enum logic [3:0] {
    PhData = 4'b0001,
    PhCrc0 = 4'b0010,
    PhCrc1 = 4'b0100,
    PhCrc2 = 4'b1000
  } phase_e;

  typedef struct packed {
    logic              fire;
    phase_e            phase;
    logic              first_byte;
    logic [ByteW-1:0]  data_byte;
    logic [ChanW-1:0]  channel;
  } dp_ctrl_t;

  typedef struct packed {
    logic [ByteW-1:0] out_byte;
    logic             is_crc;
    logic             packet_end;
  } result_t;

  typedef struct packed {
    logic [ByteW-1:0] lfsr;
    logic [ByteW-1:0] data;
  } whiten_t;

  function automatic logic [ByteW-1:0] rev8(input logic [ByteW-1:0] a);
    logic [ByteW-1:0] v;
    for (int i = 0; i < ByteW; i++) begin
      v[ByteW-1-i] = a[i];
    end
    return v;
  endfunction

  // Eight LSB-first CRC steps, shifting out of the top bit.
  function automatic logic [CrcW-1:0] crc_feed8(input logic [CrcW-1:0] crc,
                                                input logic [ByteW-1:0] d);
    logic [CrcW-1:0] c;
    logic            top;
    c = crc;
    for (int i = 0; i < ByteW; i++) begin
      top = c[CrcW-1];
      c   = {c[CrcW-2:0], 1'b0};
      if (top != d[i]) begin
        c = c ^ CrcPoly;
      end
    end
    return c;
  endfunction

  // Eight whitening steps: mask bit i is the LFSR top bit before step i.
  function automatic whiten_t whiten8(input logic [ByteW-1:0] lfsr,
                                      input logic [ByteW-1:0] d);
    whiten_t r;
    r.lfsr = lfsr;
    r.data = d;
    for (int i = 0; i < ByteW; i++) begin
      if (r.lfsr[ByteW-1]) begin
        r.lfsr    = r.lfsr ^ WhitenTap;
        r.data[i] = ~r.data[i];
      end
      r.lfsr = {r.lfsr[ByteW-2:0], 1'b0};
    end
    return r;
  endfunction

endpackage

### rtl/bpcw_if.sv
// ----------------------------------------------------------------------------
// bpcw interfaces
// Valid/ready channels for data bytes in, encoded bytes out and the CRC seed.
// ----------------------------------------------------------------------------
interface bpcw_in_if;
  logic                             valid;
  logic                             ready;
  logic [bpcw_pkg::ByteW-1:0]       data_byte;
  logic                             first_byte;
  logic                             last_data;
  logic [bpcw_pkg::ChanW-1:0]       channel;

  modport source (output valid, data_byte, first_byte, last_data, channel,
                  input ready);
  modport sink   (input valid, data_byte, first_byte, last_data, channel,
                  output ready);
endinterface

interface bpcw_out_if;
  logic                             valid;
  logic                             ready;
  logic [bpcw_pkg::ByteW-1:0]       out_byte;
  logic                             is_crc;
  logic                             packet_end;

  modport source (output valid, out_byte, is_crc, packet_end, input ready);
  modport sink   (input valid, out_byte, is_crc, packet_end, output ready);
endinterface

interface bpcw_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [bpcw_pkg::CrcW-1:0]        crc_init;

  modport source (output valid, crc_init, input ready);
  modport sink   (input valid, crc_init, output ready);
endinterface

### rtl/bpcw_seq.sv
// ----------------------------------------------------------------------------
// bpcw_seq
// Input register and byte sequencer: holds one input beat and steps it
// through its data byte and, on the last data byte, the three CRC bytes.
// ----------------------------------------------------------------------------
module bpcw_seq (
  input  logic                clk_i,
  input  logic                rst_ni,
  bpcw_in_if.sink             in_i,
  input  logic                out_space_i,
  output bpcw_pkg::dp_ctrl_t  ctrl_o
);
  import bpcw_pkg::*;

  logic             in_vld_q, in_vld_d;
  phase_e           phase_q, phase_d;
  logic [ByteW-1:0] data_q;
  logic             first_q;
  logic             last_q;
  logic [ChanW-1:0] chan_q;
  logic             fire;
  logic             done;
  logic             accept;

  assign fire = in_vld_q && out_space_i;

  always_comb begin
    unique case (phase_q)
      PhData:  done = !last_q;
      PhCrc0:  done = 1'b0;
      PhCrc1:  done = 1'b0;
      PhCrc2:  done = 1'b1;
      default: done = 1'b1;
    endcase
  end

  assign in_i.ready = !in_vld_q || (fire && done);
  assign accept     = in_i.valid && in_i.ready;

  always_comb begin
    in_vld_d = in_vld_q;
    phase_d  = phase_q;
    if (accept) begin
      in_vld_d = 1'b1;
      phase_d  = PhData;
    end else if (fire && done) begin
      in_vld_d = 1'b0;
      phase_d  = PhData;
    end else if (fire) begin
      unique case (phase_q)
        PhData:  phase_d = PhCrc0;
        PhCrc0:  phase_d = PhCrc1;
        PhCrc1:  phase_d = PhCrc2;
        PhCrc2:  phase_d = PhData;
        default: phase_d = PhData;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
      phase_q  <= PhData;
    end else begin
      in_vld_q <= in_vld_d;
      phase_q  <= phase_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      data_q  <= in_i.data_byte;
      first_q <= in_i.first_byte;
      last_q  <= in_i.last_data;
      chan_q  <= in_i.channel;
    end
  end

  assign ctrl_o.fire       = fire;
  assign ctrl_o.phase      = phase_q;
  assign ctrl_o.first_byte = first_q;
  assign ctrl_o.data_byte  = data_q;
  assign ctrl_o.channel    = chan_q;

endmodule

### rtl/bpcw_dp.sv
// ----------------------------------------------------------------------------
// bpcw_dp
// CRC and whitening datapath: seed register, CRC and LFSR state, and the
// one-byte encode step for a data byte or a CRC byte.
// ----------------------------------------------------------------------------
module bpcw_dp (
  input  logic                clk_i,
  input  logic                rst_ni,
  bpcw_cfg_if.sink            cfg_i,
  input  bpcw_pkg::dp_ctrl_t  ctrl_i,
  output bpcw_pkg::result_t   res_o
);
  import bpcw_pkg::*;

  logic [CrcW-1:0]  crc_init_q;
  logic [CrcW-1:0]  crc_q, crc_d;
  logic [ByteW-1:0] lfsr_q;
  logic [ByteW-1:0] base_lfsr;
  logic [CrcW-1:0]  base_crc;
  logic [ByteW-1:0] wh_in;
  logic             crc_byte;
  logic             end_byte;
  whiten_t          wh;

  assign cfg_i.ready = 1'b1;

  // A packet start reseeds both registers before its first byte is coded.
  assign base_crc  = ctrl_i.first_byte ? crc_init_q : crc_q;
  assign base_lfsr = ctrl_i.first_byte
                   ? (rev8({{(ByteW-ChanW){1'b0}}, ctrl_i.channel}) | WhitenSeedOr)
                   : lfsr_q;

  always_comb begin
    crc_d    = crc_q;
    wh_in    = ctrl_i.data_byte;
    crc_byte = 1'b1;
    end_byte = 1'b0;
    unique case (ctrl_i.phase)
      PhData: begin
        crc_d    = crc_feed8(base_crc, ctrl_i.data_byte);
        wh_in    = ctrl_i.data_byte;
        crc_byte = 1'b0;
      end
      PhCrc0: wh_in = rev8(crc_q[23:16]);
      PhCrc1: wh_in = rev8(crc_q[15:8]);
      PhCrc2: begin
        wh_in    = rev8(crc_q[7:0]);
        end_byte = 1'b1;
      end
      default: wh_in = ctrl_i.data_byte;
    endcase
  end

  assign wh    = whiten8((ctrl_i.phase == PhData) ? base_lfsr : lfsr_q, wh_in);
  assign res_o = {rev8(wh.data), crc_byte, end_byte};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_init_q <= CrcInitReset;
      crc_q      <= CrcInitReset;
      lfsr_q     <= '0;
    end else begin
      if (cfg_i.valid) begin
        crc_init_q <= cfg_i.crc_init;
      end
      if (ctrl_i.fire) begin
        crc_q  <= crc_d;
        lfsr_q <= wh.lfsr;
      end
    end
  end

endmodule

### rtl/bpcw_out_reg.sv
// ----------------------------------------------------------------------------
// bpcw_out_reg
// Output register that holds one encoded byte until the sink takes it.
// ----------------------------------------------------------------------------
module bpcw_out_reg (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               load_i,
  input  bpcw_pkg::result_t  res_i,
  output logic               space_o,
  bpcw_out_if.source         out_o
);
  import bpcw_pkg::*;

  logic    vld_q;
  result_t res_q;

  assign space_o = !vld_q || out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (load_i) begin
      vld_q <= 1'b1;
    end else if (out_o.ready) begin
      vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign out_o.valid      = vld_q;
  assign out_o.out_byte   = res_q.out_byte;
  assign out_o.is_crc     = res_q.is_crc;
  assign out_o.packet_end = res_q.packet_end;

endmodule

### rtl/ble_packet_crc_whiten_encoder.sv
// ----------------------------------------------------------------------------
// ble_packet_crc_whiten_encoder
// BLE link-layer encoder: CRC-24 over the packet data bytes, data whitening,
// bit reversal, and the three CRC bytes appended after the last data byte.
// ----------------------------------------------------------------------------
//
//   Channel  Dir  Beat contents
//   in_i     in   data_byte, first_byte, last_data, channel
//   out_o    out  out_byte, is_crc, packet_end
//   cfg_i    in   crc_init (24-bit CRC seed, taken at every packet start)
//
// An accepted beat is coded from the input register, and its result is loaded
// into the output register whenever that register has space for a byte.
// A middle data byte gives one output beat; the last data byte of a packet
// gives four: itself and the three CRC bytes, each via the output register.
// Reset clears the valid flags and the LFSR; the seed and CRC register return
// to 0x555555. Backpressure on out_o stalls the sequencer and then in_i.
//
module ble_packet_crc_whiten_encoder (
  input  logic        clk_i,
  input  logic        rst_ni,
  bpcw_in_if.sink     in_i,
  bpcw_out_if.source  out_o,
  bpcw_cfg_if.sink    cfg_i
);
  import bpcw_pkg::*;

  dp_ctrl_t ctrl;
  result_t  res;
  logic     out_space;

  // The sequencer holds the current input beat and walks it through its
  // data byte and, when it ends the packet, the three CRC bytes. It advances
  // only when the output register can take a byte.
  bpcw_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .out_space_i (out_space),
    .ctrl_o      (ctrl)
  );

  // The datapath owns the CRC seed, the CRC register and the whitening LFSR.
  // A first byte reseeds both before it is coded.
  bpcw_dp u_dp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .ctrl_i (ctrl),
    .res_o  (res)
  );

  // The output register holds one result for the sink. While a result waits
  // there, the sequencer stalls, and once the input register is also full
  // the next beat on in_i waits as well.
  bpcw_out_reg u_out (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (ctrl.fire),
    .res_i   (res),
    .space_o (out_space),
    .out_o   (out_o)
  );

endmodule

### rtl/bpcw_checker.sv
// ----------------------------------------------------------------------------
// bpcw_checker
// Port-level assertions for the encoder, bound to the top level.
// ----------------------------------------------------------------------------
module bpcw_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        out_valid_i,
  input logic                        out_ready_i,
  input logic [bpcw_pkg::ByteW-1:0]  out_byte_i,
  input logic                        is_crc_i,
  input logic                        packet_end_i,
  input logic                        cfg_valid_i,
  input logic                        cfg_ready_i
);

  // A stalled output beat holds its payload.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_byte_i)
      && $stable(is_crc_i) && $stable(packet_end_i))
    else $error("output beat changed while stalled");

  // The packet end only ever rides on a CRC byte.
  a_end_is_crc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && packet_end_i |-> is_crc_i)
    else $error("packet end on a data byte");

  // The seed register takes a write in any cycle.
  a_cfg_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i |-> cfg_ready_i)
    else $error("seed write refused");

endmodule

bind ble_packet_crc_whiten_encoder bpcw_checker u_bpcw_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .out_valid_i  (out_o.valid),
  .out_ready_i  (out_o.ready),
  .out_byte_i   (out_o.out_byte),
  .is_crc_i     (out_o.is_crc),
  .packet_end_i (out_o.packet_end),
  .cfg_valid_i  (cfg_i.valid),
  .cfg_ready_i  (cfg_i.ready)
);
